### src/ldacc_pkg.sv
// Shared types and constants of the labelled dose accumulator.
`timescale 1ns / 1ps
package ldacc_pkg;

   localparam int LABEL_W = 6;
   localparam int CNT_W   = 32;
   localparam int WIDE_W  = 64;
   localparam int DATA_W  = 32;
   localparam int LIMIT_W = 7;

   localparam logic REG_VOXEL_VOLUME = 1'b0;
   localparam logic REG_ORGAN_COUNT  = 1'b1;

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic               hit;
      logic               last;
      logic [WIDE_W-1:0]  energy;
      logic [DATA_W-1:0]  density;
   } item_type;

   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic [WIDE_W-1:0] energy;
      logic [WIDE_W-1:0] density;
   } bin_type;

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic [CNT_W-1:0]   count;
      logic [WIDE_W-1:0]  volume;
      logic [WIDE_W-1:0]  mass;
      logic [DATA_W-1:0]  mean;
      logic               last;
   } row_type;

endpackage

### src/ldacc_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module ldacc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### src/ldacc_queue.sv
// Short queue of classified voxels between front and back.
`timescale 1ns / 1ps
module ldacc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ldacc_pkg::item_type push_item,
   output logic                full,
   input  logic                pop,
   output ldacc_pkg::item_type pop_item,
   output logic                empty
);
   import ldacc_pkg::*;

   localparam int AW = $clog2(DEPTH);

   item_type       slot_ff [DEPTH];
   logic [AW:0]    wr_ff, wr_in;
   logic [AW:0]    rd_ff, rd_in;

   assign empty    = (wr_ff == rd_ff);
   assign full     = (wr_ff[AW-1:0] == rd_ff[AW-1:0]) && (wr_ff[AW] != rd_ff[AW]);
   assign pop_item = slot_ff[rd_ff[AW-1:0]];
   assign wr_in    = wr_ff + (AW+1)'(push && !full);
   assign rd_in    = rd_ff + (AW+1)'(pop && !empty);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
      if (push && !full) begin
         slot_ff[wr_ff[AW-1:0]] <= push_item;
      end
   end
endmodule

### src/ldacc_front.sv
// Front end: accept voxels, classify labels and form dose times density.
`timescale 1ns / 1ps
module ldacc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [7:0]                   req_organ_label,
   input  logic [ldacc_pkg::DATA_W-1:0] req_dose,
   input  logic [ldacc_pkg::DATA_W-1:0] req_density,
   input  logic                         req_last_voxel,
   input  logic [ldacc_pkg::LIMIT_W-1:0] limit,
   output logic                         q_push,
   output ldacc_pkg::item_type          q_item,
   input  logic                         q_full
);
   import ldacc_pkg::*;

   logic     s1_valid_ff, s1_valid_in;
   item_type s1_item_ff, s1_item_in;
   logic     accept;

   assign req_full = s1_valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = s1_valid_ff && !q_full;
   assign q_item   = s1_item_ff;

   always_comb begin
      s1_valid_in = accept || (s1_valid_ff && q_full);
      s1_item_in  = s1_item_ff;
      if (accept) begin
         s1_item_in.label   = req_organ_label[LABEL_W-1:0];
         s1_item_in.hit     = req_organ_label < {1'b0, limit};
         s1_item_in.last    = req_last_voxel;
         s1_item_in.energy  = WIDE_W'(req_dose) * WIDE_W'(req_density);
         s1_item_in.density = req_density;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_item_ff <= s1_item_in;
   end
endmodule

### src/ldacc_back.sv
// Back end: bin updates, report walk, row arithmetic and result register.
`timescale 1ns / 1ps
module ldacc_back #(
   parameter int NUM_ORGANS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  ldacc_pkg::item_type           q_item,
   output logic                          q_pop,
   input  logic [ldacc_pkg::DATA_W-1:0]  voxel_volume,
   input  logic [ldacc_pkg::LIMIT_W-1:0] limit,
   output ldacc_pkg::row_type            row,
   output logic                          row_valid,
   input  logic                          row_pop
);
   import ldacc_pkg::*;

   localparam int LW = NUM_ORGANS > 1 ? $clog2(NUM_ORGANS) : 1;
   localparam int BW = $bits(bin_type);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_UPD  = 10'b0000000010,
      ST_RD   = 10'b0000000100,
      ST_CHK  = 10'b0000001000,
      ST_MVOL = 10'b0000010000,
      ST_MLO  = 10'b0000100000,
      ST_MHI  = 10'b0001000000,
      ST_DIV  = 10'b0010000000,
      ST_ROW  = 10'b0100000000,
      ST_FIN  = 10'b1000000000
   } state_type;

   state_type         state_ff, state_in;
   item_type          item_ff, item_in;
   logic [LW-1:0]     idx_ff, idx_in;
   logic [NUM_ORGANS-1:0] valid_ff, valid_in;
   logic              rd_valid_ff;
   bin_type           bin_ff, bin_in;
   logic [WIDE_W-1:0] prod_ff, lo_ff, lo_in, vol_ff, vol_in;
   logic [WIDE_W-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [5:0]        step_ff, step_in;
   row_type           pend_ff, pend_in, out_ff, out_in;
   logic              pend_valid_ff, pend_valid_in, out_valid_ff, out_valid_in;

   logic [LW-1:0]     raddr;
   logic              we;
   bin_type           wbin, rbin, entry;
   logic [DATA_W-1:0] mul_b;
   logic              out_free, at_end;
   logic [WIDE_W:0]   div_t, div_d, mass_sum;
   logic              div_ge;
   row_type           new_row;
   logic [CNT_W-1:0]  cnt_inc;
   logic [WIDE_W:0]   en_sum, de_sum;

   ldacc_ram #(.WIDTH(BW), .DEPTH(NUM_ORGANS)) u_bins (
      .clock (clock),
      .we    (we),
      .waddr (item_ff.label[LW-1:0]),
      .wdata (wbin),
      .raddr (raddr),
      .rdata (rbin)
   );

   assign raddr     = (state_ff == ST_IDLE) ? q_item.label[LW-1:0] : idx_ff;
   assign entry     = rd_valid_ff ? rbin : '0;
   assign out_free  = !out_valid_ff || row_pop;
   assign at_end    = LIMIT_W'(idx_ff) == (limit - LIMIT_W'(1));
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign row       = out_ff;
   assign row_valid = out_valid_ff;
   assign we        = (state_ff == ST_UPD);

   always_comb begin
      cnt_inc      = (entry.count == '1) ? entry.count : entry.count + CNT_W'(1);
      en_sum       = {1'b0, entry.energy} + {1'b0, item_ff.energy};
      de_sum       = {1'b0, entry.density} + (WIDE_W+1)'(item_ff.density);
      wbin.count   = cnt_inc;
      wbin.energy  = en_sum[WIDE_W] ? '1 : en_sum[WIDE_W-1:0];
      wbin.density = de_sum[WIDE_W] ? '1 : de_sum[WIDE_W-1:0];
   end

   always_comb begin
      div_t  = {rem_ff, quo_ff[WIDE_W-1]};
      div_d  = {1'b0, bin_ff.density};
      div_ge = div_t >= div_d;
   end

   always_comb begin
      mass_sum       = {1'b0, prod_ff[47:0], 16'b0} + (WIDE_W+1)'(lo_ff[WIDE_W-1:16]);
      new_row.label  = LABEL_W'(idx_ff);
      new_row.count  = bin_ff.count;
      new_row.volume = vol_ff;
      new_row.mass   = (prod_ff[WIDE_W-1:48] != '0 || mass_sum[WIDE_W]) ? '1
                                                                : mass_sum[WIDE_W-1:0];
      if (bin_ff.density == '0 || voxel_volume == '0) begin
         new_row.mean = '0;
      end else if (quo_ff[WIDE_W-1:DATA_W] != '0) begin
         new_row.mean = '1;
      end else begin
         new_row.mean = quo_ff[DATA_W-1:0];
      end
      new_row.last = 1'b0;
   end

   always_comb begin
      unique case (state_ff)
         ST_MVOL: mul_b = bin_ff.count;
         ST_MLO:  mul_b = bin_ff.density[DATA_W-1:0];
         default: mul_b = bin_ff.density[WIDE_W-1:DATA_W];
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      idx_in        = idx_ff;
      valid_in      = valid_ff;
      bin_in        = bin_ff;
      lo_in         = lo_ff;
      vol_in        = vol_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !row_pop;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               item_in = q_item;
               idx_in  = '0;
               if (q_item.hit) begin
                  state_in = ST_UPD;
               end else if (q_item.last) begin
                  state_in = (limit == '0) ? ST_FIN : ST_RD;
               end
            end
         end
         ST_UPD: begin
            valid_in[item_ff.label[LW-1:0]] = 1'b1;
            if (item_ff.last) begin
               state_in = (limit == '0) ? ST_FIN : ST_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RD: begin
            state_in = ST_CHK;
         end
         ST_CHK: begin
            bin_in = entry;
            if (entry.count != '0) begin
               state_in = ST_MVOL;
            end else if (at_end) begin
               state_in = ST_FIN;
            end else begin
               idx_in   = idx_ff + LW'(1);
               state_in = ST_RD;
            end
         end
         ST_MVOL: begin
            state_in = ST_MLO;
         end
         ST_MLO: begin
            vol_in   = prod_ff;
            state_in = ST_MHI;
         end
         ST_MHI: begin
            lo_in    = prod_ff;
            rem_in   = '0;
            quo_in   = bin_ff.energy;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = div_ge ? WIDE_W'(div_t - div_d) : div_t[WIDE_W-1:0];
            quo_in  = {quo_ff[WIDE_W-2:0], div_ge};
            step_in = step_ff + 6'd1;
            if (step_ff == '1) begin
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_in       = pend_ff;
                  out_valid_in = 1'b1;
               end
               pend_in       = new_row;
               pend_valid_in = 1'b1;
               if (at_end) begin
                  state_in = ST_FIN;
               end else begin
                  idx_in   = idx_ff + LW'(1);
                  state_in = ST_RD;
               end
            end
         end
         ST_FIN: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_in       = pend_ff;
                  out_in.last  = 1'b1;
                  out_valid_in = 1'b1;
               end
               pend_valid_in = 1'b0;
               valid_in      = '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      item_ff     <= item_in;
      idx_ff      <= idx_in;
      rd_valid_ff <= valid_ff[raddr];
      bin_ff      <= bin_in;
      prod_ff     <= WIDE_W'(voxel_volume) * WIDE_W'(mul_b);
      lo_ff       <= lo_in;
      vol_ff      <= vol_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
   end
endmodule

### src/labeled_dose_accumulator_unit.sv
// Top level of the labelled dose accumulator: register port, front, queue, back.
`timescale 1ns / 1ps
// Voxels enter through a one-stage front that forms dose times density, wait in
// a four-entry queue, and update their label's bins in the back (read, then
// write of a bin RAM with one write port and a registered read port), one
// voxel at a time. A voxel marked last starts the report walk: a read and a
// check for each label with no voxels; a reported label also takes the volume
// and mass products and the 64-step shift-subtract divider for the mean dose.
// Rows leave through a one-row result register; the bins are cleared at once
// when the walk ends, through per-label valid bits, with no clearing pass.
module labeled_dose_accumulator_unit #(
   parameter int NUM_ORGANS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_organ_label,
   input  logic [31:0] req_dose,
   input  logic [31:0] req_density,
   input  logic        req_last_voxel,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [5:0]  rsp_row_label,
   output logic [31:0] rsp_voxel_count,
   output logic [63:0] rsp_organ_volume,
   output logic [63:0] rsp_organ_mass,
   output logic [31:0] rsp_mean_dose,
   output logic        rsp_last_row,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ldacc_pkg::*;

   logic [DATA_W-1:0]  voxel_volume_ff;
   logic [LIMIT_W-1:0] organ_count_ff;
   logic [LIMIT_W-1:0] limit;
   logic               cfg_write;
   logic               q_push, q_full, q_pop, q_empty;
   item_type           q_in_item, q_out_item;
   row_type            row;
   logic               row_valid;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign limit      = (organ_count_ff > LIMIT_W'(NUM_ORGANS)) ? LIMIT_W'(NUM_ORGANS)
                                                             : organ_count_ff;

   always_comb begin
      unique case (csr_paddr[2])
         REG_VOXEL_VOLUME: csr_prdata = voxel_volume_ff;
         REG_ORGAN_COUNT:  csr_prdata = 32'(organ_count_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voxel_volume_ff <= 32'h0001_0000;
         organ_count_ff  <= 7'd64;
      end else if (cfg_write) begin
         if (csr_paddr[2] == REG_VOXEL_VOLUME) begin
            voxel_volume_ff <= csr_pwdata;
         end else begin
            organ_count_ff <= csr_pwdata[LIMIT_W-1:0];
         end
      end
   end

   ldacc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_organ_label (req_organ_label),
      .req_dose        (req_dose),
      .req_density     (req_density),
      .req_last_voxel  (req_last_voxel),
      .limit           (limit),
      .q_push          (q_push),
      .q_item          (q_in_item),
      .q_full          (q_full)
   );

   ldacc_queue #(.DEPTH(4)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_out_item),
      .empty     (q_empty)
   );

   ldacc_back #(.NUM_ORGANS(NUM_ORGANS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_item       (q_out_item),
      .q_pop        (q_pop),
      .voxel_volume (voxel_volume_ff),
      .limit        (limit),
      .row          (row),
      .row_valid    (row_valid),
      .row_pop      (rsp_pop)
   );

   assign rsp_empty        = !row_valid;
   assign rsp_row_label    = row.label;
   assign rsp_voxel_count  = row.count;
   assign rsp_organ_volume = row.volume;
   assign rsp_organ_mass   = row.mass;
   assign rsp_mean_dose    = row.mean;
   assign rsp_last_row     = row.last;

   a_row_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_voxel_count != '0)
      else $error("reported row with zero count");

   a_row_label_in_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> 7'(rsp_row_label) < limit)
      else $error("reported label beyond limit");

   a_row_held: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_row_label) && $stable(rsp_last_row)))
      else $error("waiting row changed before it was taken");
endmodule
